/* rtl/tcp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants of the tile chunky-to-planar unit.
// ----------------------------------------------------------------------------
package tcp_pkg;

    localparam int unsigned PLANES      = 4;
    localparam logic [1:0]  PLANE_LAST  = 2'd3;
    localparam logic [1:0]  SLOT_LAST   = 2'd3;

    typedef enum logic [1:0] {
        OPACITY_TRANSPARENT = 2'd0,
        OPACITY_OPAQUE      = 2'd1,
        OPACITY_PARTIAL     = 2'd2
    } opacity_t;

    // one completed group of eight pixels, all four planes
    typedef struct packed {
        logic [7:0]                tile;
        logic [4:0]                offset;
        logic [PLANES-1:0][7:0]    planes;
        logic                      done;
        opacity_t                  opacity;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage : tcp_pkg
`default_nettype wire

/* rtl/tile_chunky_to_planar_unit.sv */
`default_nettype none
// Path: a completed group is written into the group queue and then loaded
//   into the back register, from which its plane bytes reach the result ports.
// Throughput: one packed byte per cycle unless full; four plane bytes leave
//   one per cycle from the back register on pop, fed by a two-entry group queue.
// Reset: byte position, plane accumulators, colour flags, queue and output
//   state are cleared asynchronously; no clearing pass.
// ----------------------------------------------------------------------------
// tile_chunky_to_planar_unit
// Converts 4bpp packed tile bytes to four bit-plane bytes per eight pixels
// and reports tile opacity with the final plane byte.
// ----------------------------------------------------------------------------
module tile_chunky_to_planar_unit #(
    parameter int unsigned TILE_WIDTH  = 16,
    parameter int unsigned TILE_HEIGHT = 16,
    parameter int unsigned NUM_TILES   = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  tile_number,
    input  wire logic [7:0]  packed_pair,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_tile,
    output logic [1:0]       plane_index,
    output logic [4:0]       plane_offset,
    output logic [7:0]       plane_bits,
    output logic [1:0]       tile_opacity,
    output logic             tile_done
);
    import tcp_pkg::*;

    group_t        front_grp, fifo_grp;
    fifo_status_t  fifo_st;
    logic          in_xfer, grp_push, grp_take;

    assign full    = fifo_st.full;
    assign in_xfer = push && !full;

    tcp_front #(
        .TILE_WIDTH  (TILE_WIDTH),
        .TILE_HEIGHT (TILE_HEIGHT),
        .NUM_TILES   (NUM_TILES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_xfer),
        .tile_number (tile_number),
        .packed_pair (packed_pair),
        .grp         (front_grp),
        .grp_push    (grp_push)
    );

    tcp_group_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (grp_push),
        .wr_data (front_grp),
        .rd_en   (grp_take),
        .rd_data (fifo_grp),
        .status  (fifo_st)
    );

    tcp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .grp          (fifo_grp),
        .grp_avail    (!fifo_st.empty),
        .grp_take     (grp_take),
        .pop          (pop),
        .empty        (empty),
        .out_tile     (out_tile),
        .plane_index  (plane_index),
        .plane_offset (plane_offset),
        .plane_bits   (plane_bits),
        .tile_opacity (tile_opacity),
        .tile_done    (tile_done)
    );

    // back register refills before the queue backs up
    a_full_implies_output: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_st.full |-> !empty)
        else $error("queue full while output empty");

    a_done_on_last_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && tile_done) |-> (plane_index == PLANE_LAST))
        else $error("tile_done off plane 3");

    a_opacity_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (tile_opacity != OPACITY_TRANSPARENT)) |-> tile_done)
        else $error("opacity reported without tile_done");

    a_plane_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && (plane_index != PLANE_LAST))
            |=> (!empty && (plane_index == $past(plane_index) + 2'd1)))
        else $error("plane sequence broken");

endmodule : tile_chunky_to_planar_unit
`default_nettype wire

/* rtl/tcp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_front
// Takes packed pixel bytes, builds the four plane bytes of each group and
// tracks the tile's colour flags; issues one group record per group of a tile below NUM_TILES.
// ----------------------------------------------------------------------------
module tcp_front #(
    parameter int unsigned TILE_WIDTH  = 16,
    parameter int unsigned TILE_HEIGHT = 16,
    parameter int unsigned NUM_TILES   = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     tile_number,
    input  wire logic [7:0]     packed_pair,
    output tcp_pkg::group_t     grp,
    output logic                grp_push
);
    import tcp_pkg::*;

    localparam int unsigned BYTES = (TILE_WIDTH * TILE_HEIGHT) / 2;
    localparam int unsigned POS_W = $clog2(BYTES);

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [PLANES-1:0][7:0]  acc_reg, acc_next, acc_sum;
    logic                    clear_reg, clear_next;
    logic                    colored_reg, colored_next;

    logic [POS_W+4:0]        pos_ext;
    logic [1:0]              slot;
    logic [3:0]              hi_px, lo_px;
    logic [2:0]              hi_bit, lo_bit;
    logic                    last, clear_sum, colored_sum, in_range;

    assign pos_ext  = {5'b0, pos_reg};
    assign slot     = pos_reg[1:0];
    assign hi_px    = packed_pair[7:4];
    assign lo_px    = packed_pair[3:0];
    assign hi_bit   = 3'd7 - {slot, 1'b0};
    assign lo_bit   = hi_bit - 3'd1;
    assign last     = (pos_reg == POS_W'(BYTES - 1));
    assign in_range = (NUM_TILES >= 256) || (tile_number < 8'(NUM_TILES));

    assign clear_sum   = clear_reg | (hi_px == 4'd0) | (lo_px == 4'd0);
    assign colored_sum = colored_reg | (hi_px != 4'd0) | (lo_px != 4'd0);

    always_comb
    begin
        acc_sum = acc_reg;
        for (int p = 0; p < PLANES; p++)
        begin
            acc_sum[p][hi_bit] = acc_reg[p][hi_bit] | hi_px[p];
            acc_sum[p][lo_bit] = acc_reg[p][lo_bit] | lo_px[p];
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        clear_next   = clear_reg;
        colored_next = colored_reg;
        if (accept)
        begin
            acc_next     = (slot == SLOT_LAST) ? '0 : acc_sum;
            pos_next     = last ? '0 : pos_reg + POS_W'(1);
            clear_next   = last ? 1'b0 : clear_sum;
            colored_next = last ? 1'b0 : colored_sum;
        end
    end

    always_comb
    begin
        grp.tile    = tile_number;
        grp.offset  = pos_ext[6:2];
        grp.planes  = acc_sum;
        grp.done    = last;
        if (!colored_sum)
            grp.opacity = OPACITY_TRANSPARENT;
        else if (!clear_sum)
            grp.opacity = OPACITY_OPAQUE;
        else
            grp.opacity = OPACITY_PARTIAL;
    end

    assign grp_push = accept && (slot == SLOT_LAST) && in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            acc_reg     <= '0;
            clear_reg   <= 1'b0;
            colored_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            clear_reg   <= clear_next;
            colored_reg <= colored_next;
        end
    end

endmodule : tcp_front
`default_nettype wire

/* rtl/tcp_group_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_group_fifo
// Two-entry queue of group records between the front and the back.
// ----------------------------------------------------------------------------
module tcp_group_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire tcp_pkg::group_t    wr_data,
    input  wire logic               rd_en,
    output tcp_pkg::group_t         rd_data,
    output tcp_pkg::fifo_status_t   status
);
    import tcp_pkg::*;

    group_t      slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_wr, do_rd;

    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({do_wr, do_rd})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule : tcp_group_fifo
`default_nettype wire

/* rtl/tcp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_back
// Holds one group record and hands out its four plane bytes in order.
// ----------------------------------------------------------------------------
module tcp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tcp_pkg::group_t grp,
    input  wire logic           grp_avail,
    output logic                grp_take,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          out_tile,
    output logic [1:0]          plane_index,
    output logic [4:0]          plane_offset,
    output logic [7:0]          plane_bits,
    output logic [1:0]          tile_opacity,
    output logic                tile_done
);
    import tcp_pkg::*;

    group_t      hold_reg;
    logic        valid_reg, valid_next;
    logic [1:0]  plane_reg, plane_next;
    logic        xfer, load;

    assign xfer     = pop && valid_reg;
    // refill once the last plane leaves, or whenever empty
    assign load     = !valid_reg || (xfer && (plane_reg == PLANE_LAST));
    assign grp_take = load && grp_avail;

    always_comb
    begin
        valid_next = valid_reg;
        plane_next = plane_reg;
        if (load)
        begin
            valid_next = grp_avail;
            plane_next = 2'd0;
        end
        else if (xfer)
        begin
            plane_next = plane_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_take)
            hold_reg <= grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            plane_reg <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            plane_reg <= plane_next;
        end
    end

    assign empty        = !valid_reg;
    assign out_tile     = hold_reg.tile;
    assign plane_index  = plane_reg;
    assign plane_offset = hold_reg.offset;
    assign plane_bits   = hold_reg.planes[plane_reg];
    assign tile_done    = hold_reg.done && (plane_reg == PLANE_LAST);
    assign tile_opacity = tile_done ? hold_reg.opacity : OPACITY_TRANSPARENT;

endmodule : tcp_back
`default_nettype wire
